// File: hw/rtl/jcbf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jcbf_pkg
// Shared types, constants and helper functions of the joint command framer.
// ============================================================================
package jcbf_pkg;

    // Frame geometry
    localparam int NUM_AXES    = 6;
    localparam int DATA_BYTES  = 13;
    localparam int FRAME_BYTES = 17;
    localparam int FRAME_CHARS = 25;
    localparam int STREAM_W    = 8 * (FRAME_BYTES + 1);

    // Step conversion
    localparam logic [15:0] STEP_OFFSET = 16'd32000;
    localparam logic [15:0] STEP_MAX    = 16'h7FFF;
    localparam logic [15:0] STEP_MIN    = 16'h8000;
    localparam logic [31:0] STEP_POS_LIMIT = 32'd32767;
    localparam logic [31:0] STEP_NEG_LIMIT = 32'd32768;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY_REFL = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOR_OUT   = 32'hFFFFFFFF;

    // Characters
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [4:0] CHAR_IDX_FIRST = 5'd0;
    localparam logic [4:0] CHAR_IDX_LAST  = 5'(FRAME_CHARS - 1);

    // Configuration registers
    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_IDX_STEPS  = 1'b0;
    localparam logic [0:0] REG_IDX_THRESH = 1'b1;
    localparam logic [31:0] STEPS_RESET  = 32'd65536;
    localparam logic [31:0] THRESH_RESET = 32'd655;

    typedef logic [DATA_BYTES-1:0][7:0] data_bytes_t;

    // Beat moving through the CRC chain
    typedef struct packed {
        data_bytes_t data;
        logic [31:0] crc;
    } crc_beat_t;

    // One byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [31:0] c;
        c = crc_in ^ {24'h000000, data_in};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // RFC 4648 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;
        else if (v < 6'd52)
            return w + 8'd71;
        else if (v < 6'd62)
            return w - 8'd4;
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

// File: hw/rtl/jcbf_scale.sv
`timescale 1ns / 1ps
// ============================================================================
// jcbf_scale
// Four-stage lane pipeline: angle magnitude, gain multiply, rounding,
// saturation with offset; also the gripper compare. Emits the 13 data bytes.
// ============================================================================
module jcbf_scale
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [jcbf_pkg::NUM_AXES-1:0][31:0]    angles,
    input  logic [31:0]                            level,
    input  logic [31:0]                            gain,
    input  logic [31:0]                            threshold,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output jcbf_pkg::data_bytes_t                  out_data
);

    localparam int NA = jcbf_pkg::NUM_AXES;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [NA-1:0]       neg1_reg, neg2_reg, neg3_reg;
    logic [NA-1:0][31:0] mag1_reg;
    logic [NA-1:0][63:0] prod2_reg;
    logic [NA-1:0][31:0] rnd3_reg;
    logic                grip1_reg, grip2_reg, grip3_reg;
    jcbf_pkg::data_bytes_t data4_reg;

    logic [NA-1:0][31:0] mag1_next;
    logic [NA-1:0][63:0] prod2_next;
    logic [NA-1:0][31:0] rnd3_next;
    jcbf_pkg::data_bytes_t data4_next;

    // Stall chain: a stage loads when empty or when the next one moves
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Per-lane datapath
    always_comb
    begin
        logic [15:0] s;
        data4_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            mag1_next[i]  = angles[i][31] ? (~angles[i] + 32'd1) : angles[i];
            prod2_next[i] = 64'(mag1_reg[i]) * 64'(gain);
            rnd3_next[i]  = prod2_reg[i][63:32] + {31'd0, prod2_reg[i][31]};
            if (neg3_reg[i])
                s = (rnd3_reg[i] >= jcbf_pkg::STEP_NEG_LIMIT) ? jcbf_pkg::STEP_MIN
                                                              : (16'd0 - rnd3_reg[i][15:0]);
            else
                s = (rnd3_reg[i] >= jcbf_pkg::STEP_POS_LIMIT) ? jcbf_pkg::STEP_MAX
                                                              : rnd3_reg[i][15:0];
            s = s + jcbf_pkg::STEP_OFFSET;
            data4_next[2*i]   = s[7:0];
            data4_next[2*i+1] = s[15:8];
        end
        data4_next[jcbf_pkg::DATA_BYTES-1] = {7'd0, grip3_reg};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            for (int i = 0; i < NA; i++)
            begin
                neg1_reg[i] <= angles[i][31];
            end
            mag1_reg  <= mag1_next;
            grip1_reg <= ($signed(level) > $signed(threshold));
        end
        if (rdy2 && v1_reg)
        begin
            neg2_reg  <= neg1_reg;
            prod2_reg <= prod2_next;
            grip2_reg <= grip1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            neg3_reg  <= neg2_reg;
            rnd3_reg  <= rnd3_next;
            grip3_reg <= grip2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            data4_reg <= data4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = data4_reg;

endmodule

// File: hw/rtl/jcbf_crc_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// jcbf_crc_stage
// One CRC pipeline stage: folds the lowest data byte into the running CRC and
// rotates the byte array by one, so after all stages the order is restored.
// ============================================================================
module jcbf_crc_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  jcbf_pkg::crc_beat_t   in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output jcbf_pkg::crc_beat_t   out_beat
);

    logic                valid_reg;
    jcbf_pkg::crc_beat_t beat_reg;
    jcbf_pkg::crc_beat_t beat_next;

    assign in_ready = !valid_reg || out_ready;

    // Byte update and rotate
    always_comb
    begin
        beat_next.crc  = jcbf_pkg::crc_byte(in_beat.crc, in_beat.data[0]);
        beat_next.data = {in_beat.data[0],
                          in_beat.data[jcbf_pkg::DATA_BYTES-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: hw/rtl/jcbf_serializer.sv
`timescale 1ns / 1ps
// ============================================================================
// jcbf_serializer
// Frame register and character sequencer: newline, 23 base64 characters
// taken six bits at a time from a shift register, then the pad character.
// ============================================================================
module jcbf_serializer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  jcbf_pkg::crc_beat_t   in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            frame_char,
    output logic                  frame_last
);

    localparam int SW = jcbf_pkg::STREAM_W;

    logic          busy_reg;
    logic [4:0]    idx_reg;
    logic [SW-1:0] stream_reg;
    logic [SW-1:0] stream_next;
    logic [31:0]   crc_final;
    logic          out_fire;
    logic          load;

    // Bytes in send order, CRC low byte first, one zero pad byte
    always_comb
    begin
        crc_final   = in_beat.crc ^ jcbf_pkg::CRC_XOR_OUT;
        stream_next = '0;
        for (int i = 0; i < jcbf_pkg::DATA_BYTES; i++)
        begin
            stream_next[SW-1-8*i -: 8] = in_beat.data[i];
        end
        for (int k = 0; k < 4; k++)
        begin
            stream_next[SW-1-8*(jcbf_pkg::DATA_BYTES+k) -: 8] = crc_final[8*k +: 8];
        end
    end

    assign frame_last = (idx_reg == jcbf_pkg::CHAR_IDX_LAST);
    assign out_fire   = busy_reg && out_ready;
    assign in_ready   = !busy_reg || (out_ready && frame_last);
    assign load       = in_ready && in_valid;

    // Character select
    always_comb
    begin
        if (idx_reg == jcbf_pkg::CHAR_IDX_FIRST)
            frame_char = jcbf_pkg::CHAR_NEWLINE;
        else if (frame_last)
            frame_char = jcbf_pkg::CHAR_PAD;
        else
            frame_char = jcbf_pkg::b64_char(stream_reg[SW-1 -: 6]);
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= jcbf_pkg::CHAR_IDX_FIRST;
        end
        else if (in_ready)
        begin
            busy_reg <= in_valid;
            idx_reg  <= jcbf_pkg::CHAR_IDX_FIRST;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + 5'd1;
        end
    end

    // Shift one sextet out after each base64 character
    always_ff @(posedge clk)
    begin
        if (load)
            stream_reg <= stream_next;
        else if (out_fire && idx_reg != jcbf_pkg::CHAR_IDX_FIRST)
            stream_reg <= stream_reg << 6;
    end

    assign out_valid = busy_reg;

    // A frame, once started, is not dropped before its last character
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_last) |=> out_valid)
        else $error("frame ended before last character");

    // A newly loaded frame opens with the newline
    a_first_newline: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (frame_char == jcbf_pkg::CHAR_NEWLINE))
        else $error("frame does not start with newline");

    // No new frame is taken while one is still being sent
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !(out_ready && frame_last)) |-> !in_ready)
        else $error("frame loaded over one in flight");

    // Index advances by one per accepted non-final character
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !frame_last) |=> (idx_reg == $past(idx_reg) + 5'd1))
        else $error("character index skipped");

endmodule

// File: hw/rtl/joint_command_crc_base64_framer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// joint_command_crc_base64_framer_unit
// Joint command framer: six scaled step counts and a gripper flag, CRC-32,
// base64 text frame of a newline and 24 characters.
// ============================================================================
//
//  Channel | Direction | Handshake                     | Payload
//  --------+-----------+-------------------------------+---------------------------
//  in      | input     | in_valid / in_ready           | axis0..5_angle, gripper_level
//  out     | output    | out_valid / out_ready         | frame_char, frame_last
//  cfg     | input     | psel penable pwrite, pready=1 | paddr, pwdata, prdata
//
//  Each command yields 25 beats on out; the serializer sends one character per
//  cycle while out_ready is high and loads the next frame as the last character is taken.
//  The first character is offered once the command has passed 18 registers
//  (4 scale stages, 13 CRC stages, frame register), and after any wait behind an
//  earlier frame and any output stall.
//  The 17-stage pipeline keeps taking commands while a frame is being sent
//  and holds them under backpressure; nothing is lost or repeated.
//  Reset returns both registers to their defaults and empties the pipeline.
//
module joint_command_crc_base64_framer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     axis0_angle,
    input  logic [31:0]                     axis1_angle,
    input  logic [31:0]                     axis2_angle,
    input  logic [31:0]                     axis3_angle,
    input  logic [31:0]                     axis4_angle,
    input  logic [31:0]                     axis5_angle,
    input  logic [31:0]                     gripper_level,
    // frame channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      frame_char,
    output logic                            frame_last,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jcbf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int NB = jcbf_pkg::DATA_BYTES;

    logic [31:0] steps_reg;
    logic [31:0] thresh_reg;
    logic        cfg_write;
    logic [0:0]  cfg_idx;

    logic                   sc_valid, sc_ready;
    jcbf_pkg::data_bytes_t  sc_data;

    logic                   crc_valid [NB+1];
    logic                   crc_ready [NB+1];
    jcbf_pkg::crc_beat_t    crc_beat  [NB+1];

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[jcbf_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg  <= jcbf_pkg::STEPS_RESET;
            thresh_reg <= jcbf_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                jcbf_pkg::REG_IDX_STEPS:  steps_reg  <= pwdata;
                jcbf_pkg::REG_IDX_THRESH: thresh_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            jcbf_pkg::REG_IDX_STEPS:  prdata = steps_reg;
            jcbf_pkg::REG_IDX_THRESH: prdata = thresh_reg;
            default:                  prdata = '0;
        endcase
    end

    // Scaling pipeline
    jcbf_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angles    ({axis5_angle, axis4_angle, axis3_angle,
                     axis2_angle, axis1_angle, axis0_angle}),
        .level     (gripper_level),
        .gain      (steps_reg),
        .threshold (thresh_reg),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_data  (sc_data)
    );

    // CRC chain, one byte per stage
    assign crc_valid[0]     = sc_valid;
    assign sc_ready         = crc_ready[0];
    assign crc_beat[0].data = sc_data;
    assign crc_beat[0].crc  = jcbf_pkg::CRC_INIT;

    for (genvar g = 0; g < NB; g++)
    begin : g_crc
        jcbf_crc_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (crc_valid[g]),
            .in_ready  (crc_ready[g]),
            .in_beat   (crc_beat[g]),
            .out_valid (crc_valid[g+1]),
            .out_ready (crc_ready[g+1]),
            .out_beat  (crc_beat[g+1])
        );
    end

    // Frame register and character output
    jcbf_serializer u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (crc_valid[NB]),
        .in_ready   (crc_ready[NB]),
        .in_beat    (crc_beat[NB]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_char (frame_char),
        .frame_last (frame_last)
    );

endmodule

// File: bench/joint_command_crc_base64_framer_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// joint_command_crc_base64_framer_unit_test
// Self-checking bench for the joint command framer. Commands go in on a
// valid/ready channel, and the framer's text characters are checked one beat
// at a time against frames that the bench builds itself: step scaling with
// rounding and saturation, the gripper flag, CRC-32 and base64 with padding.
// Both registers are written and read back over the register port in several
// settings. Both channels idle at random, and the output is also held off
// for a long stretch so that the pipeline fills and the input stalls.
// ============================================================================
module joint_command_crc_base64_framer_unit_test;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [jcbf_pkg::CFG_ADDR_W-1:0] STEPS_ADDR  =
        {jcbf_pkg::REG_IDX_STEPS, 2'b00};
    localparam logic [jcbf_pkg::CFG_ADDR_W-1:0] THRESH_ADDR =
        {jcbf_pkg::REG_IDX_THRESH, 2'b00};

    typedef struct packed {
        logic [jcbf_pkg::NUM_AXES-1:0][31:0] angle;
        logic [31:0]                         gripper;
    } command_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } frame_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [31:0]                     axis0_angle;
    logic [31:0]                     axis1_angle;
    logic [31:0]                     axis2_angle;
    logic [31:0]                     axis3_angle;
    logic [31:0]                     axis4_angle;
    logic [31:0]                     axis5_angle;
    logic [31:0]                     gripper_level;
    logic                            out_valid;
    logic                            out_ready;
    logic [7:0]                      frame_char;
    logic                            frame_last;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [jcbf_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    // bench copy of the registers
    logic [31:0] gain_setting;
    logic [31:0] thresh_setting;

    frame_beat_t expected_frame_chars[$];
    int          error_count;
    int          cycle_count;
    logic        no_idle_mode;
    int          hold_ticket;
    int          hold_served;
    int          hold_left;
    string       b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    joint_command_crc_base64_framer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .axis0_angle   (axis0_angle),
        .axis1_angle   (axis1_angle),
        .axis2_angle   (axis2_angle),
        .axis3_angle   (axis3_angle),
        .axis4_angle   (axis4_angle),
        .axis5_angle   (axis5_angle),
        .gripper_level (gripper_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_char    (frame_char),
        .frame_last    (frame_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Build the 25 characters of one frame and queue them
    function automatic void predict_frame(input command_t cmd);
        logic [7:0]  frame_bytes [jcbf_pkg::FRAME_BYTES+1];
        logic [7:0]  text [jcbf_pkg::FRAME_CHARS];
        logic        negative;
        logic [32:0] mag;
        logic [63:0] prod;
        logic [63:0] rounded;
        logic [15:0] steps;
        logic [31:0] crc;
        logic [23:0] group;
        frame_beat_t beat;

        // scale, round half away from zero, saturate, offset
        for (int i = 0; i < jcbf_pkg::NUM_AXES; i++)
        begin
            negative = cmd.angle[i][31];
            mag      = negative ? (33'd0 - {1'b1, cmd.angle[i]}) : {1'b0, cmd.angle[i]};
            prod     = 64'(mag) * 64'(gain_setting);
            rounded  = (prod + 64'h8000_0000) >> 32;
            if (negative)
                steps = (rounded >= 64'(jcbf_pkg::STEP_NEG_LIMIT)) ? jcbf_pkg::STEP_MIN
                                                                   : (16'd0 - rounded[15:0]);
            else
                steps = (rounded >= 64'(jcbf_pkg::STEP_POS_LIMIT)) ? jcbf_pkg::STEP_MAX
                                                                   : rounded[15:0];
            steps = steps + jcbf_pkg::STEP_OFFSET;
            frame_bytes[2*i]   = steps[7:0];
            frame_bytes[2*i+1] = steps[15:8];
        end
        frame_bytes[12] = ($signed(cmd.gripper) > $signed(thresh_setting)) ? 8'd1 : 8'd0;

        // reflected CRC-32 over the data bytes
        crc = jcbf_pkg::CRC_INIT;
        for (int i = 0; i < jcbf_pkg::DATA_BYTES; i++)
        begin
            crc = crc ^ {24'd0, frame_bytes[i]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ jcbf_pkg::CRC_POLY_REFL) : (crc >> 1);
        end
        crc = crc ^ jcbf_pkg::CRC_XOR_OUT;
        frame_bytes[13] = crc[7:0];
        frame_bytes[14] = crc[15:8];
        frame_bytes[15] = crc[23:16];
        frame_bytes[16] = crc[31:24];
        frame_bytes[17] = 8'd0;

        // base64, last group carries one pad character
        text[0] = jcbf_pkg::CHAR_NEWLINE;
        for (int g = 0; g < 6; g++)
        begin
            group = {frame_bytes[3*g], frame_bytes[3*g+1], frame_bytes[3*g+2]};
            for (int s = 3; s >= 0; s--)
                text[1 + 4*g + (3 - s)] = b64_alphabet[group[6*s +: 6]];
        end
        text[jcbf_pkg::FRAME_CHARS-1] = jcbf_pkg::CHAR_PAD;

        for (int i = 0; i < jcbf_pkg::FRAME_CHARS; i++)
        begin
            beat.ch   = text[i];
            beat.last = (i == jcbf_pkg::FRAME_CHARS - 1);
            expected_frame_chars.push_back(beat);
        end
    endfunction

    // frame checker
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frame_chars.size() == 0)
            begin
                $error("frame_char: unexpected beat, actual %02h", frame_char);
                error_count++;
            end
            else
            begin
                want = expected_frame_chars.pop_front();
                if (frame_char !== want.ch)
                begin
                    $error("frame_char: expected %02h, actual %02h", want.ch, frame_char);
                    error_count++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0b, actual %0b", want.last, frame_last);
                    error_count++;
                end
            end
        end
    end

    // output side: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (no_idle_mode)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 9);
    end

    // One command beat, with random idle cycles ahead of it
    task automatic send_command(input command_t cmd);
        if (!no_idle_mode)
        begin
            while ($urandom_range(99) < 9)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        axis0_angle   <= cmd.angle[0];
        axis1_angle   <= cmd.angle[1];
        axis2_angle   <= cmd.angle[2];
        axis3_angle   <= cmd.angle[3];
        axis4_angle   <= cmd.angle[4];
        axis5_angle   <= cmd.angle[5];
        gripper_level <= cmd.gripper;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_frame(cmd);
    endtask

    task automatic wait_frames_done();
        in_valid <= 1'b0;
        while (expected_frame_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [jcbf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == STEPS_ADDR)
            gain_setting = data;
        else if (addr == THRESH_ADDR)
            thresh_setting = data;
    endtask

    task automatic reg_read_check(input logic [jcbf_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [31:0] want, input string field);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $error("%s: expected %08h, actual %08h", field, want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only called with the block idle
    task automatic apply_config(input logic [31:0] gain, input logic [31:0] thresh);
        reg_write(STEPS_ADDR, gain);
        reg_write(THRESH_ADDR, thresh);
        reg_read_check(STEPS_ADDR, gain, "steps_per_radian");
        reg_read_check(THRESH_ADDR, thresh, "gripper_threshold");
    endtask

    function automatic logic [31:0] random_angle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom;
        else if (pick < 80)
            return 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
        else
            return {16'($urandom_range(16'hFFFF)), 16'h8000};
    endfunction

    function automatic command_t random_command();
        command_t cmd;
        for (int i = 0; i < jcbf_pkg::NUM_AXES; i++)
            cmd.angle[i] = random_angle();
        if ($urandom_range(1))
            cmd.gripper = $urandom;
        else
            cmd.gripper = thresh_setting + 32'($urandom_range(4)) - 32'd2;
        return cmd;
    endfunction

    function automatic command_t make_command(input logic [31:0] a0, input logic [31:0] a1,
                                              input logic [31:0] a2, input logic [31:0] a3,
                                              input logic [31:0] a4, input logic [31:0] a5,
                                              input logic [31:0] grip);
        command_t cmd;
        cmd.angle   = {a5, a4, a3, a2, a1, a0};
        cmd.gripper = grip;
        return cmd;
    endfunction

    task automatic test_register_reset_values();
        gain_setting   = jcbf_pkg::STEPS_RESET;
        thresh_setting = jcbf_pkg::THRESH_RESET;
        reg_read_check(STEPS_ADDR, jcbf_pkg::STEPS_RESET, "steps_per_radian");
        reg_read_check(THRESH_ADDR, jcbf_pkg::THRESH_RESET, "gripper_threshold");
    endtask

    task automatic test_directed_commands();
        // reset gain of 1.0: half steps, saturation, gripper tie
        send_command(make_command(0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF,
                                  32'hFFFF_8001, 32'h7FFF_8000, 32'h8000_0000, 32'd655));
        send_command(make_command(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                                  32'h7FFF_7FFF, 32'h0001_0000, 32'hFFFF_0000, 32'd656));
        send_command(make_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_command(make_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        wait_frames_done();

        // largest gain, lowest threshold
        apply_config(32'hFFFF_FFFF, 32'h8000_0000);
        send_command(make_command(32'd1, 32'hFFFF_FFFF, 32'h0000_8000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000));
        send_command(make_command(32'd2, 32'hFFFF_FFFE, 32'h0000_4000,
                                  32'hFFFF_C000, 32'h0000_0100, 32'd3, 32'h8000_0001));
        wait_frames_done();

        // zero gain, highest threshold
        apply_config(32'd0, 32'h7FFF_FFFF);
        send_command(make_command(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                                  32'hFFFF_FFFF, 32'd1, 32'h0000_8000, 32'h7FFF_FFFF));
        send_command(make_command(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h5555_5555,
                                  32'hAAAA_AAAA, 32'hCAFE_0000, 32'h0000_CAFE, 32'h7FFF_FFFE));
        wait_frames_done();

        // gain of 2.0: half steps at the saturation edges
        apply_config(32'h0002_0000, 32'd0);
        send_command(make_command(32'hBFFF_C000, 32'hC000_0000, 32'h3FFF_C000,
                                  32'hC000_4000, 32'h3FFF_BFFF, 32'hC000_4001, 32'd0));
        send_command(make_command(32'h0000_4000, 32'hFFFF_C000, 32'h0000_3FFF,
                                  32'h4000_0000, 32'hBFFF_0000, 32'd0, 32'd1));
        wait_frames_done();
    endtask

    task automatic test_random_commands();
        logic [31:0] gain;
        logic [31:0] thresh;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: gain = $urandom_range(32'h00FF_FFFF);
                1: gain = $urandom;
                2: gain = jcbf_pkg::STEPS_RESET;
                default: gain = $urandom_range(32'h007F_FFFF);
            endcase
            thresh = (phase == 1) ? $urandom
                                  : 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
            apply_config(gain, thresh);
            for (int n = 0; n < 12; n++)
                send_command(random_command());
            wait_frames_done();
        end
    endtask

    // Output held off while commands keep coming: pipeline fills, input stalls
    task automatic test_output_backpressure();
        apply_config($urandom_range(32'h0040_0000), $urandom);
        hold_ticket <= hold_ticket + 1;
        for (int n = 0; n < 30; n++)
            send_command(random_command());
        wait_frames_done();
    endtask

    task automatic test_no_idle_burst();
        apply_config($urandom_range(32'h0100_0000), jcbf_pkg::STEPS_RESET);
        no_idle_mode <= 1'b1;
        for (int n = 0; n < 20; n++)
            send_command(random_command());
        wait_frames_done();
        no_idle_mode <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        axis0_angle   = '0;
        axis1_angle   = '0;
        axis2_angle   = '0;
        axis3_angle   = '0;
        axis4_angle   = '0;
        axis5_angle   = '0;
        gripper_level = '0;
        out_ready     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        no_idle_mode  = 1'b0;
        hold_ticket   = 0;
        hold_served   = 0;
        hold_left     = 0;
        gain_setting  = jcbf_pkg::STEPS_RESET;
        thresh_setting = jcbf_pkg::THRESH_RESET;

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset_values();
        test_directed_commands();
        test_random_commands();
        test_output_backpressure();
        test_no_idle_burst();

        wait_frames_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
